@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ hw/rtl/ecpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ecpa_pkg
// Types, constants and modular helpers for the affine point adder.
// ----------------------------------------------------------------------------
package ecpa_pkg;

  localparam int FIELD_BITS = 62;
  localparam int CNT_W      = $clog2(FIELD_BITS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(64'd11783108327);
  localparam logic [FIELD_BITS-1:0] COEFF_A_RESET = '0;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_COEFF_A = 2'd1;

  typedef logic [FIELD_BITS-1:0] fe_t;

  typedef enum logic {
    ALU_DIV = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  function automatic fe_t f_madd(fe_t a, fe_t b, fe_t p);
    logic [FIELD_BITS:0] s;
    logic [FIELD_BITS:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, p};
    return (s >= {1'b0, p}) ? d[FIELD_BITS-1:0] : s[FIELD_BITS-1:0];
  endfunction

  function automatic fe_t f_msub(fe_t a, fe_t b, fe_t p);
    return (a >= b) ? (a - b) : (a + (p - b));
  endfunction

endpackage

@@ hw/rtl/ec_affine_point_add_unit.sv @@
// ----------------------------------------------------------------------------
// ec_affine_point_add_unit
// Affine point addition on a short Weierstrass curve over a prime field.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries P (p_x, p_y, p_inf) and
//   Q (q_x, q_y, q_inf). One result R = P + Q leaves on out_valid/out_ready.
//   Config channel cfg_valid/cfg_ready writes field_modulus (index 0) and
//   curve_coeff_a (index 1); cfg_ready is always high, write only when idle.
//   One item at a time: in_ready is high only while the sequencer is idle.
//   Every step runs on one bit-serial divide/multiply unit. Reduction of
//   the operands is 5 operations; a chord addition then takes about
//   3 multiplies plus the extended Euclid inverse, which costs one divide
//   and one multiply per quotient step (up to ~90 steps for 62-bit
//   moduli). Infinity operands finish right after reduction.
//   A finished result sits in the output register; if the receiver stalls
//   the next item may already be taken and computed, and it waits in its
//   final state until the output register frees up.
//   Reset (synchronous, rst high) restores the register defaults and drops
//   any item in flight and any pending result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ec_affine_point_add_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ecpa_pkg::FIELD_BITS-1:0] p_x,
  input  logic [ecpa_pkg::FIELD_BITS-1:0] p_y,
  input  logic                           p_inf,
  input  logic [ecpa_pkg::FIELD_BITS-1:0] q_x,
  input  logic [ecpa_pkg::FIELD_BITS-1:0] q_y,
  input  logic                           q_inf,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ecpa_pkg::FIELD_BITS-1:0] r_x,
  output logic [ecpa_pkg::FIELD_BITS-1:0] r_y,
  output logic                           r_inf,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ecpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecpa_pkg::FIELD_BITS-1:0] cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_RED   = 12'b0000_0000_0010,
    S_CHK   = 12'b0000_0000_0100,
    S_SQ    = 12'b0000_0000_1000,
    S_TRI   = 12'b0000_0001_0000,
    S_ITST  = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_QMUL  = 12'b0000_1000_0000,
    S_MULM  = 12'b0001_0000_0000,
    S_MULS  = 12'b0010_0000_0000,
    S_MULU  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t             state;
  ecpa_pkg::fe_t      field_modulus;
  ecpa_pkg::fe_t      curve_coeff_a;

  // working registers
  ecpa_pkg::fe_t      pm;
  ecpa_pkg::fe_t      v0, v1, v2, v3, v4;   // px, py, qx, qy, a after reduction
  logic               pinf, qinf;
  logic [2:0]         red_cnt;
  ecpa_pkg::fe_t      num, tq, r0, r1, t0, t1, m, rx;
  ecpa_pkg::fe_t      res_x, res_y;
  logic               res_inf;
  logic               issued;

  ecpa_pkg::alu_req_t alu_req;
  ecpa_pkg::alu_rsp_t alu_rsp;
  ecpa_pkg::fe_t      alu_a, alu_b, alu_res, alu_quo;
  logic               op_state;
  ecpa_pkg::fe_t      qm;
  ecpa_pkg::fe_t      pxr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_modulus <= ecpa_pkg::MODULUS_RESET;
      curve_coeff_a <= ecpa_pkg::COEFF_A_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ecpa_pkg::REG_FIELD_MODULUS: field_modulus <= cfg_data;
        ecpa_pkg::REG_CURVE_COEFF_A: curve_coeff_a <= cfg_data;
        default: ;
      endcase
    end
  end

  assign op_state = (state == S_RED) || (state == S_SQ) || (state == S_TRI) ||
                    (state == S_DIV) || (state == S_QMUL) || (state == S_MULM) ||
                    (state == S_MULS) || (state == S_MULU);

  assign pxr = ecpa_pkg::f_msub(v0, rx, pm);

  always_comb begin
    alu_req.start = op_state && !issued && !alu_rsp.busy;
    alu_req.op    = ecpa_pkg::ALU_MUL;
    alu_a         = v0;
    alu_b         = v0;
    case (state)
      S_RED:  begin alu_req.op = ecpa_pkg::ALU_DIV; alu_a = v0; alu_b = pm; end
      S_SQ:   begin alu_a = v0; alu_b = v0; end
      S_TRI:  begin alu_a = tq; alu_b = ecpa_pkg::fe_t'(3); end
      S_DIV:  begin alu_req.op = ecpa_pkg::ALU_DIV; alu_a = r0; alu_b = r1; end
      S_QMUL: begin alu_a = tq; alu_b = t1; end
      S_MULM: begin alu_a = num; alu_b = t0; end
      S_MULS: begin alu_a = m; alu_b = m; end
      S_MULU: begin alu_a = m; alu_b = pxr; end
      default: ;
    endcase
  end

  // quotient reduced mod p; it never exceeds p here
  assign qm = (alu_quo >= pm) ? (alu_quo - pm) : alu_quo;

  ecpa_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (alu_a),
    .b   (alu_b),
    .p   (pm),
    .rsp (alu_rsp),
    .res (alu_res),
    .quo (alu_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE the output register is handled by the state itself
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      if (alu_req.start) issued <= 1'b1;
      if (alu_rsp.done)  issued <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pm      <= field_modulus;
            v0      <= p_x;
            v1      <= p_y;
            v2      <= q_x;
            v3      <= q_y;
            v4      <= curve_coeff_a;
            pinf    <= p_inf;
            qinf    <= q_inf;
            red_cnt <= '0;
            res_x   <= '0;
            res_y   <= '0;
            res_inf <= 1'b1;
            state   <= (field_modulus < ecpa_pkg::fe_t'(3)) ? S_DONE : S_RED;
          end
        end
        S_RED: begin
          if (alu_rsp.done) begin
            v0 <= v1; v1 <= v2; v2 <= v3; v3 <= v4; v4 <= alu_res;
            red_cnt <= red_cnt + 1'b1;
            if (red_cnt == 3'd4) state <= S_CHK;
          end
        end
        S_CHK: begin
          r0 <= pm;
          t0 <= '0;
          t1 <= ecpa_pkg::fe_t'(1);
          if (qinf) begin
            if (!pinf) begin res_x <= v0; res_y <= v1; res_inf <= 1'b0; end
            state <= S_DONE;
          end else if (pinf) begin
            res_x <= v2; res_y <= v3; res_inf <= 1'b0;
            state <= S_DONE;
          end else if (v0 == v2 && ecpa_pkg::f_madd(v1, v3, pm) == '0) begin
            state <= S_DONE;
          end else if (v0 == v2 && v1 == v3) begin
            state <= S_SQ;
          end else begin
            num   <= ecpa_pkg::f_msub(v1, v3, pm);
            r1    <= ecpa_pkg::f_msub(v0, v2, pm);
            state <= S_ITST;
          end
        end
        S_SQ: begin
          if (alu_rsp.done) begin
            tq    <= alu_res;
            state <= S_TRI;
          end
        end
        S_TRI: begin
          if (alu_rsp.done) begin
            num   <= ecpa_pkg::f_madd(alu_res, v4, pm);
            r1    <= ecpa_pkg::f_madd(v1, v1, pm);
            state <= S_ITST;
          end
        end
        S_ITST: begin
          if (r1 == '0) begin
            state <= (r0 == ecpa_pkg::fe_t'(1)) ? S_MULM : S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (alu_rsp.done) begin
            r0    <= r1;
            r1    <= alu_res;
            tq    <= qm;
            state <= S_QMUL;
          end
        end
        S_QMUL: begin
          if (alu_rsp.done) begin
            t0    <= t1;
            t1    <= ecpa_pkg::f_msub(t0, alu_res, pm);
            state <= S_ITST;
          end
        end
        S_MULM: begin
          if (alu_rsp.done) begin
            m     <= alu_res;
            state <= S_MULS;
          end
        end
        S_MULS: begin
          if (alu_rsp.done) begin
            rx    <= ecpa_pkg::f_msub(alu_res, ecpa_pkg::f_madd(v0, v2, pm), pm);
            state <= S_MULU;
          end
        end
        S_MULU: begin
          if (alu_rsp.done) begin
            res_x   <= rx;
            res_y   <= ecpa_pkg::f_msub(alu_res, v1, pm);
            res_inf <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            r_x       <= res_x;
            r_y       <= res_y;
            r_inf     <= res_inf;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_inf_zero, (out_valid && r_inf) |-> (r_x == '0 && r_y == '0))
  `ASSERT_CLK(a_take_then_busy, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_CLK(a_alu_only_in_op, alu_rsp.busy |-> op_state)
  `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(r_x)))

endmodule

@@ hw/rtl/ecpa_alu.sv @@
// ----------------------------------------------------------------------------
// ecpa_alu
// Bit-serial shared unit: restoring divide (quotient and remainder) or
// shift-add modular multiply, one bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecpa_alu (
  input  logic               clk,
  input  logic               rst,
  input  ecpa_pkg::alu_req_t req,
  input  ecpa_pkg::fe_t      a,
  input  ecpa_pkg::fe_t      b,
  input  ecpa_pkg::fe_t      p,
  output ecpa_pkg::alu_rsp_t rsp,
  output ecpa_pkg::fe_t      res,
  output ecpa_pkg::fe_t      quo
);

  localparam int W = ecpa_pkg::FIELD_BITS;

  logic                       busy;
  logic                       done;
  ecpa_pkg::alu_op_t          op_r;
  logic [ecpa_pkg::CNT_W-1:0] cnt;
  ecpa_pkg::fe_t              acc;
  ecpa_pkg::fe_t              aa;
  ecpa_pkg::fe_t              bb;
  ecpa_pkg::fe_t              dv;
  logic [W:0]                 sh;
  logic [W:0]                 sh_sub;

  assign sh     = {acc, aa[W-1]};
  assign sh_sub = sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        op_r <= req.op;
        acc  <= '0;
        aa   <= a;
        bb   <= (req.op == ecpa_pkg::ALU_MUL) ? b : '0;
        dv   <= (req.op == ecpa_pkg::ALU_MUL) ? p : b;
      end else if (busy) begin
        case (op_r)
          ecpa_pkg::ALU_DIV: begin
            aa <= {aa[W-2:0], 1'b0};
            if (sh >= {1'b0, dv}) begin
              acc <= sh_sub[W-1:0];
              bb  <= {bb[W-2:0], 1'b1};
            end else begin
              acc <= sh[W-1:0];
              bb  <= {bb[W-2:0], 1'b0};
            end
          end
          ecpa_pkg::ALU_MUL: begin
            if (bb[0]) acc <= ecpa_pkg::f_madd(acc, aa, dv);
            aa <= ecpa_pkg::f_madd(aa, aa, dv);
            bb <= {1'b0, bb[W-1:1]};
          end
          default: ;
        endcase
        cnt <= cnt + 1'b1;
        if (cnt == ecpa_pkg::CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign res      = acc;
  assign quo      = bb;

  `ASSERT_CLK(a_done_ends_busy, done |-> !busy)
  `ASSERT_CLK(a_no_start_busy, busy |-> !req.start)
  `ASSERT_CLK(a_start_to_busy, (req.start && !busy) |=> (busy && cnt == '0))

endmodule
